[rtl/vcrf_pkg.sv]
// Shared types and codes for the video command register file.
`default_nettype none
package vcrf_pkg;

    // Bus operation carried by each input beat.
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    // Command codes written to offset 0.
    typedef enum logic [7:0] {
        CMD_NOP        = 8'd0,
        CMD_CLEAR      = 8'd1,
        CMD_SET_MODE   = 8'd2,
        CMD_FONT_SEL   = 8'd3,
        CMD_BLIT       = 8'd4,
        CMD_FB_BASE    = 8'd5,
        CMD_VBLANK     = 8'd6,
        CMD_FONT_LOAD  = 8'd7,
        CMD_PAL_LOAD   = 8'd8,
        CMD_BG_COLOR   = 8'd9,
        CMD_FG_COLOR   = 8'd10,
        CMD_REG_CLEAR  = 8'd11,
        CMD_FB_SIZE    = 8'd12,
        CMD_PIX_DEPTH  = 8'd13,
        CMD_CB_BASE    = 8'd14,
        CMD_CB_SIZE    = 8'd15,
        CMD_CHAR_DEPTH = 8'd16,
        CMD_FONT_INFO  = 8'd17,
        CMD_MODE_INFO  = 8'd18,
        CMD_SCR_INFO   = 8'd19,
        CMD_CUR_SET    = 8'd20,
        CMD_CUR_CTL    = 8'd21,
        CMD_CUR_GET    = 8'd22
    } t_cmd;

    // Register window offsets.
    localparam logic [3:0] OFF_CMD = 4'd0;
    localparam logic [3:0] OFF_DH  = 4'd1;
    localparam logic [3:0] OFF_DM  = 4'd2;
    localparam logic [3:0] OFF_DL  = 4'd3;
    localparam logic [3:0] OFF_G0  = 4'd4;
    localparam logic [3:0] OFF_G1  = 4'd5;
    localparam logic [3:0] OFF_ST0 = 4'd12;
    localparam logic [3:0] OFF_ST1 = 4'd13;
    localparam logic [3:0] OFF_ST2 = 4'd14;
    localparam logic [3:0] OFF_ST3 = 4'd15;

    localparam int NUM_REGS = 16;

    // Status pattern for an unknown command.
    localparam logic [7:0] BAD_CMD_B0 = 8'hDE;
    localparam logic [7:0] BAD_CMD_B1 = 8'hAD;
    localparam logic [7:0] BAD_CMD_B2 = 8'hBE;
    localparam logic [7:0] BAD_CMD_B3 = 8'hEF;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] reg_offset;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        vblank_irq;
        logic        clear_start;
        logic [7:0]  video_mode;
        logic [7:0]  bytes_per_char;
        logic [7:0]  bytes_per_pixel;
        logic [23:0] frame_base;
        logic [23:0] char_base;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [7:0]  cells_wide;
        logic [7:0]  cells_high;
    } t_out_item;

endpackage
`default_nettype wire

[rtl/vcrf_regs.sv]
// Register window state and command execution for one bus beat.
`default_nettype none
module vcrf_regs #(
    parameter int SCREEN_W         = 640,
    parameter int SCREEN_H         = 480,
    parameter int FB_RESET_BASE    = 0,
    parameter int CB_RESET_BASE    = 0,
    parameter int MONO_MODE_CODE   = 0,
    parameter int CURSOR_RESET_CTL = 3
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire vcrf_pkg::t_in_item  i_item,
    output vcrf_pkg::t_out_item      o_result
);

    localparam int CellW = (SCREEN_W / 8 < 1) ? 1 : ((SCREEN_W / 8 > 255) ? 255 : SCREEN_W / 8);
    localparam int CellH = (SCREEN_H / 16 < 1) ? 1 : ((SCREEN_H / 16 > 255) ? 255 : SCREEN_H / 16);
    localparam logic [7:0] MonoCode = 8'(MONO_MODE_CODE);

    logic [7:0]  r_bytes [vcrf_pkg::NUM_REGS];
    logic [7:0]  r_mode, r_char_depth, r_pix_depth, r_vblank_on, r_cur_ctl;
    logic [23:0] r_fb_base, r_cb_base;
    logic [15:0] r_fb_w, r_fb_h, r_cur_pos;
    logic [7:0]  r_cb_w, r_cb_h;

    logic [7:0]  n_bytes [vcrf_pkg::NUM_REGS];
    logic [7:0]  n_mode, n_char_depth, n_pix_depth, n_vblank_on, n_cur_ctl;
    logic [23:0] n_fb_base, n_cb_base;
    logic [15:0] n_fb_w, n_fb_h, n_cur_pos;
    logic [7:0]  n_cb_w, n_cb_h;

    logic        is_write, is_cmd, clr;
    logic [7:0]  rd;
    logic [15:0] size_w, size_h;

    always_comb begin
        n_bytes      = r_bytes;
        n_mode       = r_mode;
        n_char_depth = r_char_depth;
        n_pix_depth  = r_pix_depth;
        n_vblank_on  = r_vblank_on;
        n_cur_ctl    = r_cur_ctl;
        n_fb_base    = r_fb_base;
        n_cb_base    = r_cb_base;
        n_fb_w       = r_fb_w;
        n_fb_h       = r_fb_h;
        n_cur_pos    = r_cur_pos;
        n_cb_w       = r_cb_w;
        n_cb_h       = r_cb_h;
        clr          = 1'b0;
        size_w       = {r_bytes[vcrf_pkg::OFF_DH], r_bytes[vcrf_pkg::OFF_DM]};
        size_h       = {r_bytes[vcrf_pkg::OFF_G0], r_bytes[vcrf_pkg::OFF_G1]};

        is_write = (vcrf_pkg::t_op'(i_item.op) == vcrf_pkg::OP_WRITE);
        is_cmd   = is_write && (i_item.reg_offset == vcrf_pkg::OFF_CMD);
        rd       = (vcrf_pkg::t_op'(i_item.op) == vcrf_pkg::OP_READ)
                   ? r_bytes[i_item.reg_offset] : 8'd0;

        if (is_write && !is_cmd) begin
            n_bytes[i_item.reg_offset] = i_item.write_data;
        end

        if (is_cmd) begin
            unique case (vcrf_pkg::t_cmd'(i_item.write_data))
                vcrf_pkg::CMD_CLEAR: clr = 1'b1;
                vcrf_pkg::CMD_SET_MODE: begin
                    n_mode       = r_bytes[vcrf_pkg::OFF_DH];
                    n_char_depth = (r_bytes[vcrf_pkg::OFF_DH] == MonoCode) ? 8'd1 : 8'd2;
                end
                vcrf_pkg::CMD_FB_BASE: begin
                    n_fb_base = {r_bytes[vcrf_pkg::OFF_DH], r_bytes[vcrf_pkg::OFF_DM],
                                 r_bytes[vcrf_pkg::OFF_DL]};
                end
                vcrf_pkg::CMD_VBLANK: n_vblank_on = r_bytes[vcrf_pkg::OFF_DH];
                vcrf_pkg::CMD_REG_CLEAR: begin
                    for (int i = 0; i < vcrf_pkg::NUM_REGS; i++) begin
                        n_bytes[i] = 8'd0;
                    end
                end
                vcrf_pkg::CMD_FB_SIZE: begin
                    // zero keeps the old dimension
                    if (size_w != 16'd0) n_fb_w = size_w;
                    if (size_h != 16'd0) n_fb_h = size_h;
                end
                vcrf_pkg::CMD_PIX_DEPTH: n_pix_depth = r_bytes[vcrf_pkg::OFF_DH];
                vcrf_pkg::CMD_CB_BASE: begin
                    n_cb_base = {r_bytes[vcrf_pkg::OFF_DH], r_bytes[vcrf_pkg::OFF_DM],
                                 r_bytes[vcrf_pkg::OFF_DL]};
                end
                vcrf_pkg::CMD_CB_SIZE: begin
                    if (r_bytes[vcrf_pkg::OFF_DH] != 8'd0) n_cb_w = r_bytes[vcrf_pkg::OFF_DH];
                    if (r_bytes[vcrf_pkg::OFF_DM] != 8'd0) n_cb_h = r_bytes[vcrf_pkg::OFF_DM];
                end
                vcrf_pkg::CMD_CHAR_DEPTH: n_char_depth = r_bytes[vcrf_pkg::OFF_DH];
                vcrf_pkg::CMD_MODE_INFO: begin
                    n_bytes[vcrf_pkg::OFF_ST0] = r_mode;
                    n_bytes[vcrf_pkg::OFF_ST1] = r_char_depth;
                    n_bytes[vcrf_pkg::OFF_ST2] = r_pix_depth;
                    n_bytes[vcrf_pkg::OFF_ST3] = 8'd0;
                end
                vcrf_pkg::CMD_SCR_INFO: begin
                    n_bytes[vcrf_pkg::OFF_ST0] = 8'(SCREEN_W >> 8);
                    n_bytes[vcrf_pkg::OFF_ST1] = 8'(SCREEN_W);
                    n_bytes[vcrf_pkg::OFF_ST2] = 8'(SCREEN_H >> 8);
                    n_bytes[vcrf_pkg::OFF_ST3] = 8'(SCREEN_H);
                end
                vcrf_pkg::CMD_CUR_SET: begin
                    n_cur_pos = {r_bytes[vcrf_pkg::OFF_DM], r_bytes[vcrf_pkg::OFF_DL]};
                end
                vcrf_pkg::CMD_CUR_CTL: begin
                    n_cur_ctl                 = r_bytes[vcrf_pkg::OFF_DL];
                    n_bytes[vcrf_pkg::OFF_DH] = r_bytes[vcrf_pkg::OFF_DL];
                    n_bytes[vcrf_pkg::OFF_DM] = r_cur_pos[15:8];
                    n_bytes[vcrf_pkg::OFF_DL] = r_cur_pos[7:0];
                end
                vcrf_pkg::CMD_CUR_GET: begin
                    n_bytes[vcrf_pkg::OFF_DH] = r_cur_ctl;
                    n_bytes[vcrf_pkg::OFF_DM] = r_cur_pos[15:8];
                    n_bytes[vcrf_pkg::OFF_DL] = r_cur_pos[7:0];
                end
                // colour, font, blit and palette commands hold no state on this port
                vcrf_pkg::CMD_NOP, vcrf_pkg::CMD_FONT_SEL, vcrf_pkg::CMD_BLIT,
                vcrf_pkg::CMD_FONT_LOAD, vcrf_pkg::CMD_PAL_LOAD, vcrf_pkg::CMD_BG_COLOR,
                vcrf_pkg::CMD_FG_COLOR, vcrf_pkg::CMD_FONT_INFO: ;
                default: begin
                    n_bytes[vcrf_pkg::OFF_ST0] = vcrf_pkg::BAD_CMD_B0;
                    n_bytes[vcrf_pkg::OFF_ST1] = vcrf_pkg::BAD_CMD_B1;
                    n_bytes[vcrf_pkg::OFF_ST2] = vcrf_pkg::BAD_CMD_B2;
                    n_bytes[vcrf_pkg::OFF_ST3] = vcrf_pkg::BAD_CMD_B3;
                end
            endcase
        end
    end

    always_comb begin
        o_result.read_data       = rd;
        o_result.vblank_irq      = (vcrf_pkg::t_op'(i_item.op) == vcrf_pkg::OP_TICK)
                                   && (r_vblank_on != 8'd0);
        o_result.clear_start     = clr;
        o_result.video_mode      = n_mode;
        o_result.bytes_per_char  = n_char_depth;
        o_result.bytes_per_pixel = n_pix_depth;
        o_result.frame_base      = n_fb_base;
        o_result.char_base       = n_cb_base;
        o_result.frame_width     = n_fb_w;
        o_result.frame_height    = n_fb_h;
        o_result.cells_wide      = n_cb_w;
        o_result.cells_high      = n_cb_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < vcrf_pkg::NUM_REGS; i++) begin
                r_bytes[i] <= 8'd0;
            end
            r_mode       <= MonoCode;
            r_char_depth <= 8'd1;
            r_pix_depth  <= 8'd4;
            r_vblank_on  <= 8'd0;
            r_cur_ctl    <= 8'(CURSOR_RESET_CTL);
            r_fb_base    <= 24'(FB_RESET_BASE);
            r_cb_base    <= 24'(CB_RESET_BASE);
            r_fb_w       <= 16'(SCREEN_W);
            r_fb_h       <= 16'(SCREEN_H);
            r_cur_pos    <= 16'd0;
            r_cb_w       <= 8'(CellW);
            r_cb_h       <= 8'(CellH);
        end else if (i_en) begin
            r_bytes      <= n_bytes;
            r_mode       <= n_mode;
            r_char_depth <= n_char_depth;
            r_pix_depth  <= n_pix_depth;
            r_vblank_on  <= n_vblank_on;
            r_cur_ctl    <= n_cur_ctl;
            r_fb_base    <= n_fb_base;
            r_cb_base    <= n_cb_base;
            r_fb_w       <= n_fb_w;
            r_fb_h       <= n_fb_h;
            r_cur_pos    <= n_cur_pos;
            r_cb_w       <= n_cb_w;
            r_cb_h       <= n_cb_h;
        end
    end

endmodule
`default_nettype wire

[rtl/video_command_register_file_unit.sv]
// Top level of the video command register file: input stage, register file, result stage.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | into unit | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//  out     | from unit | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// One beat per cycle sustained while the output is not stalled; a taken beat is registered in the
// input stage and its result in the result stage. The command decode and state update sit between
// the input and result registers. Reset (synchronous, active low) empties both stages and loads the
// default state. A stall on the output holds the result; the input stalls only when both stages are
// full and the output is stalled.
`default_nettype none
module video_command_register_file_unit #(
    parameter int SCREEN_W         = 640,
    parameter int SCREEN_H         = 480,
    parameter int FB_RESET_BASE    = 0,
    parameter int CB_RESET_BASE    = 0,
    parameter int MONO_MODE_CODE   = 0,
    parameter int CURSOR_RESET_CTL = 3
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire vcrf_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output vcrf_pkg::t_out_item      o_out_item
);

    logic                r_in_valid;
    vcrf_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    vcrf_pkg::t_out_item r_out_item;
    vcrf_pkg::t_out_item result;
    logic                adv, take;

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign take       = i_in_valid && !o_in_stall;

    vcrf_regs #(
        .SCREEN_W        (SCREEN_W),
        .SCREEN_H        (SCREEN_H),
        .FB_RESET_BASE   (FB_RESET_BASE),
        .CB_RESET_BASE   (CB_RESET_BASE),
        .MONO_MODE_CODE  (MONO_MODE_CODE),
        .CURSOR_RESET_CTL(CURSOR_RESET_CTL)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_item  (r_in_item),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (take) begin
            r_in_item <= i_in_item;
        end
        if (adv) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

[rtl/vcrf_checker.sv]
// Port-level checks for the video command register file, bound to the top level.
`default_nettype none
module vcrf_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire vcrf_pkg::t_out_item o_out_item
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output beat changed");

    // input stalls only while a result is blocked downstream
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stall without output backpressure");

    // a beat is a read, a write or a tick: the three flags never coincide
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.clear_start && (o_out_item.vblank_irq
                          || o_out_item.read_data != 8'd0)))
        else $error("clear pulse together with read data or irq");

    // size commands never store a zero dimension
    a_sizes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.frame_width != 16'd0 && o_out_item.frame_height != 16'd0
                        && o_out_item.cells_wide != 8'd0 && o_out_item.cells_high != 8'd0)
        else $error("zero frame or cell dimension");

    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind video_command_register_file_unit vcrf_checker u_vcrf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);
`default_nettype wire
